[rtl/core/ccp_scan_pkg.sv]
// Shared types and constants for the class constant pool crypto scanner.
// No dependencies.
`timescale 1ns / 1ps
package ccp_scan_pkg;
    localparam int NameCount = 20;
    localparam int NameMax = 42;
    localparam int NamePosW = 6;

    typedef enum logic [7:0] {
        PH_HEADER = 8'b0000_0001,
        PH_TAG    = 8'b0000_0010,
        PH_ULEN   = 8'b0000_0100,
        PH_UTF8   = 8'b0000_1000,
        PH_INT    = 8'b0001_0000,
        PH_SKIP   = 8'b0010_0000,
        PH_DONE   = 8'b0100_0000,
        PH_ERROR  = 8'b1000_0000
    } phase_t;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_SHORT = 3'd1;
    localparam logic [2:0] ST_MAGIC = 3'd2;
    localparam logic [2:0] ST_TRUNC = 3'd3;
    localparam logic [2:0] ST_TAG = 3'd4;

    localparam logic [31:0] Magic = 32'hCAFEBABE;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    typedef struct packed {
        logic       digest_weak;
        logic       cipher_weak;
        logic       signature_weak;
        logic       keysize_weak;
        logic [2:0] scan_status;
    } result_t;

    function automatic string name_str(input int i);
        case (i)
            0: name_str = "java/security/MessageDigest";
            1: name_str = "java.security.MessageDigest";
            2: name_str = "getInstance";
            3: name_str = "MD5";
            4: name_str = "SHA1";
            5: name_str = "SHA-1";
            6: name_str = "javax/crypto/Cipher";
            7: name_str = "javax.crypto.Cipher";
            8: name_str = "DES/ECB";
            9: name_str = "RC4";
            10: name_str = "AES/ECB";
            11: name_str = "java/security/Signature";
            12: name_str = "java.security.Signature";
            13: name_str = "MD5withRSA";
            14: name_str = "SHA1withRSA";
            15: name_str = "SHA-1withRSA";
            16: name_str = "java/security/KeyPairGenerator";
            17: name_str = "java.security.KeyPairGenerator";
            18: name_str = "initialize";
            default: name_str = "java/security/KeyPairGenerator.initialize";
        endcase
    endfunction

    function automatic logic [15:0] name_len(input int i);
        name_len = 16'(name_str(i).len());
    endfunction

    // character of name i at position p, zero beyond its end
    function automatic logic [7:0] name_char(input int i, input logic [NamePosW-1:0] p);
        string s;
        s = name_str(i);
        if (int'(p) < s.len())
            name_char = s[int'(p)];
        else
            name_char = 8'h00;
    endfunction
endpackage

[rtl/core/ccp_scan_fifo.sv]
// Two-entry request queue between the byte front end and the parser.
// Depends on ccp_scan_pkg.
`timescale 1ns / 1ps
module ccp_scan_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  ccp_scan_pkg::byte_req_t wr_data,
    output logic                    full,
    input  logic                    rd_en,
    output ccp_scan_pkg::byte_req_t rd_data,
    output logic                    empty
);
    import ccp_scan_pkg::*;

    byte_req_t  mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en && !full)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (wr_en && !full)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en && !empty)
            begin
                rptr_reg <= ~rptr_reg;
            end
            count_reg <= count_reg + 2'((wr_en && !full) ? 1 : 0)
                - 2'((rd_en && !empty) ? 1 : 0);
        end
    end

`ifndef SYNTHESIS
    a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !rd_en) |=> full) else $error("full dropped without read");
    a_empty_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (empty && !wr_en) |=> empty) else $error("empty dropped without write");
`endif
endmodule

[rtl/core/ccp_scan_parse.sv]
// Constant pool walker, name matcher and result register.
// Depends on ccp_scan_pkg.
`timescale 1ns / 1ps
module ccp_scan_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    req_valid,
    input  ccp_scan_pkg::byte_req_t req,
    output logic                    req_take,
    output ccp_scan_pkg::result_t   res,
    output logic                    res_empty,
    input  logic                    res_pop
);
    import ccp_scan_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [4:0]           total_reg, total_next;
    logic [15:0]          slots_reg, slots_next;
    logic [15:0]          left_reg, left_next;
    logic [31:0]          acc_reg, acc_next;
    logic [NamePosW-1:0]  pos_reg, pos_next;
    logic [NameCount-1:0] alive_reg, alive_next;
    logic [NameCount-1:0] seen_reg, seen_next;
    logic [2:0]           sizes_reg, sizes_next;
    logic [2:0]           err_reg, err_next;
    result_t              res_reg, res_next;
    logic                 full_reg;

    logic [7:0]  b;
    logic        fire;
    logic [15:0] take;
    logic [15:0] ulen;
    logic [2:0]  status;

    assign res_empty = !full_reg;
    assign res = res_reg;
    assign req_take = req_valid && (!full_reg || res_pop);
    assign fire = req_take;
    assign b = req.data_byte;
    assign ulen = {acc_reg[7:0], b};

    always_comb
    begin
        phase_next = phase_reg;
        total_next = (total_reg < 5'd16) ? total_reg + 5'd1 : total_reg;
        slots_next = slots_reg;
        left_next = left_reg;
        acc_next = acc_reg;
        pos_next = pos_reg;
        alive_next = alive_reg;
        seen_next = seen_reg;
        sizes_next = sizes_reg;
        err_next = err_reg;
        take = 16'd1;
        case (phase_reg)
            PH_HEADER:
            begin
                acc_next = {acc_reg[23:0], b};
                if (total_reg == 5'd3 && acc_next != Magic)
                begin
                    err_next = ST_MAGIC;
                    phase_next = PH_ERROR;
                end
                else if (total_reg == 5'd9)
                begin
                    slots_next = (acc_next[15:0] != 16'd0) ? acc_next[15:0] - 16'd1 : 16'd0;
                    acc_next = '0;
                    phase_next = (slots_next != 16'd0) ? PH_TAG : PH_DONE;
                end
            end
            PH_TAG:
            begin
                acc_next = '0;
                case (b)
                    8'd1:
                    begin
                        phase_next = PH_ULEN;
                        left_next = 16'd2;
                    end
                    8'd3:
                    begin
                        phase_next = PH_INT;
                        left_next = 16'd4;
                    end
                    8'd5, 8'd6:
                    begin
                        phase_next = PH_SKIP;
                        left_next = 16'd8;
                        take = 16'd2;
                    end
                    8'd7, 8'd8, 8'd16, 8'd19, 8'd20:
                    begin
                        phase_next = PH_SKIP;
                        left_next = 16'd2;
                    end
                    8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18:
                    begin
                        phase_next = PH_SKIP;
                        left_next = 16'd4;
                    end
                    8'd15:
                    begin
                        phase_next = PH_SKIP;
                        left_next = 16'd3;
                    end
                    default:
                    begin
                        err_next = ST_TAG;
                        phase_next = PH_ERROR;
                        take = 16'd0;
                    end
                endcase
                slots_next = (slots_reg > take) ? slots_reg - take : 16'd0;
            end
            PH_ULEN:
            begin
                acc_next = {16'd0, ulen};
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    for (int i = 0; i < NameCount; i++)
                    begin
                        alive_next[i] = (name_len(i) == ulen);
                    end
                    pos_next = '0;
                    if (ulen == 16'd0)
                    begin
                        phase_next = (slots_reg == 16'd0) ? PH_DONE : PH_TAG;
                    end
                    else
                    begin
                        left_next = ulen;
                        phase_next = PH_UTF8;
                    end
                end
            end
            PH_UTF8:
            begin
                for (int i = 0; i < NameCount; i++)
                begin
                    if (name_char(i, pos_reg) != b || 16'(pos_reg) >= name_len(i))
                    begin
                        alive_next[i] = 1'b0;
                    end
                end
                if (pos_reg < NamePosW'(NameMax))
                begin
                    pos_next = pos_reg + NamePosW'(1);
                end
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    seen_next = seen_reg | alive_next;
                    phase_next = (slots_reg == 16'd0) ? PH_DONE : PH_TAG;
                end
            end
            PH_INT:
            begin
                acc_next = {acc_reg[23:0], b};
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    sizes_next = sizes_reg | {acc_next == 32'd1024, acc_next == 32'd768,
                        acc_next == 32'd512};
                    phase_next = (slots_reg == 16'd0) ? PH_DONE : PH_TAG;
                end
            end
            PH_SKIP:
            begin
                left_next = left_reg - 16'd1;
                if (left_next == 16'd0)
                begin
                    phase_next = (slots_reg == 16'd0) ? PH_DONE : PH_TAG;
                end
            end
            default:
            begin
            end
        endcase

        if (total_next < 5'd16)
            status = ST_SHORT;
        else if (err_next != ST_OK)
            status = err_next;
        else if (phase_next != PH_DONE && phase_next != PH_TAG)
            status = ST_TRUNC;
        else
            status = ST_OK;
        res_next.scan_status = status;
        res_next.digest_weak = (status == ST_OK) && (seen_next[0] | seen_next[1])
            && seen_next[2] && (seen_next[3] | seen_next[4] | seen_next[5]);
        res_next.cipher_weak = (status == ST_OK) && (seen_next[6] | seen_next[7])
            && seen_next[2] && (seen_next[8] | seen_next[9] | seen_next[10]);
        res_next.signature_weak = (status == ST_OK) && (seen_next[11] | seen_next[12])
            && seen_next[2] && (seen_next[13] | seen_next[14] | seen_next[15]);
        res_next.keysize_weak = (status == ST_OK) && (seen_next[16] | seen_next[17])
            && (seen_next[18] | seen_next[19]) && (sizes_next != 3'd0);
    end

    always_ff @(posedge clk)
    begin
        if (fire && req.last_byte)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            total_reg <= '0;
            slots_reg <= '0;
            left_reg <= '0;
            acc_reg <= '0;
            pos_reg <= '0;
            alive_reg <= '0;
            seen_reg <= '0;
            sizes_reg <= '0;
            err_reg <= '0;
            full_reg <= 1'b0;
        end
        else
        begin
            if (fire && req.last_byte)
            begin
                phase_reg <= PH_HEADER;
                total_reg <= '0;
                slots_reg <= '0;
                left_reg <= '0;
                acc_reg <= '0;
                pos_reg <= '0;
                alive_reg <= '0;
                seen_reg <= '0;
                sizes_reg <= '0;
                err_reg <= '0;
            end
            else if (fire)
            begin
                phase_reg <= phase_next;
                total_reg <= total_next;
                slots_reg <= slots_next;
                left_reg <= left_next;
                acc_reg <= acc_next;
                pos_reg <= pos_next;
                alive_reg <= alive_next;
                seen_reg <= seen_next;
                sizes_reg <= sizes_next;
                err_reg <= err_next;
            end
            if (fire && req.last_byte)
                full_reg <= 1'b1;
            else if (res_pop)
                full_reg <= 1'b0;
        end
    end

`ifndef SYNTHESIS
    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK) |-> (phase_reg == PH_ERROR)) else $error("error without error phase");
    a_flags_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (full_reg && res_reg.scan_status != ST_OK) |-> !(res_reg.digest_weak
        || res_reg.cipher_weak || res_reg.signature_weak || res_reg.keysize_weak))
        else $error("flags set on failed scan");
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= 5'd16) else $error("byte count past saturation");
`endif
endmodule

[rtl/core/class_constant_pool_crypto_scan.sv]
// Top level of the class file weak-crypto scanner.
// Depends on ccp_scan_pkg, ccp_scan_fifo and ccp_scan_parse.
//
// Usage: push one class file byte per cycle with push while full is low,
// marking the final byte with last_byte. Bytes enter a two-entry queue and
// the parser takes one byte per cycle from it. After the final byte the
// four weak-crypto flags and scan_status appear on the result ports with
// empty low; pop takes them. Empty goes low on the edge at which the parser
// takes the final byte from the queue. Throughput is one byte per cycle; the
// one-deep result register stalls the parser only while an earlier result
// waits, and the queue then fills and raises full. The next byte after a
// final byte starts a new file. Reset clears the queue, the parser and the
// result-valid flag; the result values themselves are not reset.
`timescale 1ns / 1ps
module class_constant_pool_crypto_scan (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       empty,
    input  logic       pop,
    output logic       digest_weak,
    output logic       cipher_weak,
    output logic       signature_weak,
    output logic       keysize_weak,
    output logic [2:0] scan_status
);
    import ccp_scan_pkg::*;

    byte_req_t in_req, q_req;
    logic      q_empty, q_take;
    result_t   res;

    assign in_req.data_byte = data_byte;
    assign in_req.last_byte = last_byte;

    ccp_scan_fifo u_fifo (
        .clk(clk), .rst_n(rst_n),
        .wr_en(push), .wr_data(in_req), .full(full),
        .rd_en(q_take), .rd_data(q_req), .empty(q_empty)
    );

    ccp_scan_parse u_parse (
        .clk(clk), .rst_n(rst_n),
        .req_valid(!q_empty), .req(q_req), .req_take(q_take),
        .res(res), .res_empty(empty), .res_pop(pop)
    );

    assign digest_weak = res.digest_weak;
    assign cipher_weak = res.cipher_weak;
    assign signature_weak = res.signature_weak;
    assign keysize_weak = res.keysize_weak;
    assign scan_status = res.scan_status;
endmodule

[bench/testbench.sv]
// Testbench for class_constant_pool_crypto_scan: streams class files byte by byte,
// predicts flags and status with an in-bench scanner, checks each result in order.
// Depends on ccp_scan_pkg and the RTL of the scanner.
`timescale 1ns / 1ps
module testbench;
    import ccp_scan_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       empty;
    logic       pop;
    logic       digest_weak;
    logic       cipher_weak;
    logic       signature_weak;
    logic       keysize_weak;
    logic [2:0] scan_status;

    class_constant_pool_crypto_scan dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .last_byte(last_byte), .empty(empty), .pop(pop),
        .digest_weak(digest_weak), .cipher_weak(cipher_weak),
        .signature_weak(signature_weak), .keysize_weak(keysize_weak),
        .scan_status(scan_status)
    );

    localparam logic [7:0] TAG_UTF8 = 8'd1;
    localparam logic [7:0] TAG_INT = 8'd3;
    localparam logic [7:0] TAG_BAD = 8'd2;

    string weak_names[20] = '{
        "java/security/MessageDigest", "java.security.MessageDigest",
        "getInstance", "MD5", "SHA1", "SHA-1",
        "javax/crypto/Cipher", "javax.crypto.Cipher",
        "DES/ECB", "RC4", "AES/ECB",
        "java/security/Signature", "java.security.Signature",
        "MD5withRSA", "SHA1withRSA", "SHA-1withRSA",
        "java/security/KeyPairGenerator", "java.security.KeyPairGenerator",
        "initialize", "java/security/KeyPairGenerator.initialize"
    };
    logic [7:0] other_tags[15] = '{4, 5, 6, 7, 8, 9, 10, 11, 12, 15, 16, 17, 18, 19, 20};

    result_t    expected_results[$];
    logic [7:0] file_buf[$];
    int         mismatches;
    int         hold_cycles;
    int         rx_mode;
    int         burst_left;
    int         bytes_sent;

    // scanner state
    phase_t      sc_phase;
    logic [4:0]  sc_count;
    logic [15:0] sc_slots;
    logic [15:0] sc_left;
    logic [31:0] sc_acc;
    logic [5:0]  sc_pos;
    logic [19:0] sc_alive;
    logic [19:0] sc_seen;
    logic [2:0]  sc_sizes;
    logic [2:0]  sc_err;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function void buf_add(input logic [7:0] v);
        file_buf = {file_buf, v};
    endfunction

    function void scan_clear();
        sc_phase = PH_HEADER;
        sc_count = '0;
        sc_slots = '0;
        sc_left = '0;
        sc_acc = '0;
        sc_pos = '0;
        sc_alive = '0;
        sc_seen = '0;
        sc_sizes = '0;
        sc_err = ST_OK;
    endfunction

    function void entry_finished();
        sc_phase = (sc_slots == 0) ? PH_DONE : PH_TAG;
    endfunction

    function void scan_byte(input logic [7:0] b, input logic fin);
        logic [4:0]  idx;
        logic [15:0] take;
        result_t     r;
        idx = sc_count;
        if (sc_count < 16)
            sc_count = sc_count + 1;
        case (sc_phase)
            PH_HEADER:
            begin
                sc_acc = {sc_acc[23:0], b};
                if (idx == 3 && sc_acc != Magic)
                begin
                    sc_err = ST_MAGIC;
                    sc_phase = PH_ERROR;
                end
                else if (idx == 9)
                begin
                    sc_slots = (sc_acc[15:0] != 0) ? sc_acc[15:0] - 1 : 16'd0;
                    sc_acc = '0;
                    sc_phase = (sc_slots != 0) ? PH_TAG : PH_DONE;
                end
            end
            PH_TAG:
            begin
                take = 1;
                sc_acc = '0;
                case (b)
                    1: begin sc_phase = PH_ULEN; sc_left = 2; end
                    3: begin sc_phase = PH_INT; sc_left = 4; end
                    5, 6: begin sc_phase = PH_SKIP; sc_left = 8; take = 2; end
                    7, 8, 16, 19, 20: begin sc_phase = PH_SKIP; sc_left = 2; end
                    4, 9, 10, 11, 12, 17, 18: begin sc_phase = PH_SKIP; sc_left = 4; end
                    15: begin sc_phase = PH_SKIP; sc_left = 3; end
                    default:
                    begin
                        sc_err = ST_TAG;
                        sc_phase = PH_ERROR;
                        take = 0;
                    end
                endcase
                sc_slots = (sc_slots > take) ? sc_slots - take : 16'd0;
            end
            PH_ULEN:
            begin
                sc_acc = {16'd0, sc_acc[7:0], b};
                sc_left = sc_left - 1;
                if (sc_left == 0)
                begin
                    sc_alive = '0;
                    for (int i = 0; i < 20; i++)
                        if (weak_names[i].len() == sc_acc)
                            sc_alive[i] = 1'b1;
                    sc_pos = '0;
                    if (sc_acc == 0)
                        entry_finished();
                    else
                    begin
                        sc_left = sc_acc[15:0];
                        sc_phase = PH_UTF8;
                    end
                end
            end
            PH_UTF8:
            begin
                for (int i = 0; i < 20; i++)
                    if (sc_alive[i] && (sc_pos >= weak_names[i].len()
                                        || weak_names[i][sc_pos] != b))
                        sc_alive[i] = 1'b0;
                if (sc_pos < 42)
                    sc_pos = sc_pos + 1;
                sc_left = sc_left - 1;
                if (sc_left == 0)
                begin
                    sc_seen = sc_seen | sc_alive;
                    entry_finished();
                end
            end
            PH_INT:
            begin
                sc_acc = {sc_acc[23:0], b};
                sc_left = sc_left - 1;
                if (sc_left == 0)
                begin
                    if (sc_acc == 512) sc_sizes[0] = 1'b1;
                    if (sc_acc == 768) sc_sizes[1] = 1'b1;
                    if (sc_acc == 1024) sc_sizes[2] = 1'b1;
                    entry_finished();
                end
            end
            PH_SKIP:
            begin
                sc_left = sc_left - 1;
                if (sc_left == 0)
                    entry_finished();
            end
            default: ;
        endcase
        if (fin)
        begin
            r = '0;
            if (sc_count < 16)
                r.scan_status = ST_SHORT;
            else if (sc_err != ST_OK)
                r.scan_status = sc_err;
            else if (sc_phase inside {PH_ULEN, PH_UTF8, PH_INT, PH_SKIP, PH_HEADER})
                r.scan_status = ST_TRUNC;
            else
                r.scan_status = ST_OK;
            if (r.scan_status == ST_OK)
            begin
                r.digest_weak = (sc_seen[0] | sc_seen[1]) & sc_seen[2]
                              & (sc_seen[3] | sc_seen[4] | sc_seen[5]);
                r.cipher_weak = (sc_seen[6] | sc_seen[7]) & sc_seen[2]
                              & (sc_seen[8] | sc_seen[9] | sc_seen[10]);
                r.signature_weak = (sc_seen[11] | sc_seen[12]) & sc_seen[2]
                                 & (sc_seen[13] | sc_seen[14] | sc_seen[15]);
                r.keysize_weak = (sc_seen[16] | sc_seen[17]) & (sc_seen[18] | sc_seen[19])
                               & (sc_sizes != 0);
            end
            expected_results = {expected_results, r};
            scan_clear();
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        data_byte <= b;
        last_byte <= fin;
        push <= 1'b1;
        @(negedge clk);
        while (full)
            @(negedge clk);
        @(posedge clk);
        scan_byte(b, fin);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(1, 15);
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
    endtask

    task automatic start_file(input logic [15:0] pool_count);
        file_buf = '{8'hCA, 8'hFE, 8'hBA, 8'hBE};
        repeat (4) buf_add(8'($urandom));
        buf_add(pool_count[15:8]);
        buf_add(pool_count[7:0]);
    endtask

    task automatic add_utf8(input string s);
        buf_add(TAG_UTF8);
        buf_add(8'(s.len() >> 8));
        buf_add(8'(s.len()));
        for (int i = 0; i < s.len(); i++)
            buf_add(s[i]);
    endtask

    task automatic add_int(input logic [31:0] v);
        buf_add(TAG_INT);
        for (int i = 3; i >= 0; i--)
            buf_add(v[8*i +: 8]);
    endtask

    function automatic int skip_len(input logic [7:0] t);
        case (t)
            5, 6: return 8;
            7, 8, 16, 19, 20: return 2;
            15: return 3;
            default: return 4;
        endcase
    endfunction

    task automatic add_other(input logic [7:0] t);
        buf_add(t);
        repeat (skip_len(t)) buf_add(8'($urandom));
    endtask

    task automatic test_length_and_magic();
        file_buf = '{8'hFF};
        send_file();
        file_buf = '{8'h00};
        send_file();
        start_file(16'd1);
        repeat (5) buf_add(8'h00);
        send_file();
        start_file(16'd1);
        file_buf[2] = 8'hBB;
        repeat (6) buf_add(8'hFF);
        send_file();
        start_file(16'd0);
        repeat (6) buf_add(8'($urandom));
        send_file();
    endtask

    task automatic test_weak_flags();
        start_file(16'd4);
        add_utf8("java/security/MessageDigest");
        add_utf8("getInstance");
        add_utf8("MD5");
        send_file();
        start_file(16'd4);
        add_utf8("javax.crypto.Cipher");
        add_utf8("RC4");
        add_utf8("getInstance");
        send_file();
        start_file(16'd5);
        add_utf8("java/security/Signature");
        add_utf8("getInstance");
        add_utf8("SHA-1withRSA");
        add_utf8("");
        send_file();
        start_file(16'd6);
        add_utf8("java.security.KeyPairGenerator");
        add_utf8("java/security/KeyPairGenerator.initialize");
        add_int(32'd512);
        add_int(32'd768);
        add_int(32'd1024);
        send_file();
        start_file(16'd5);
        add_utf8("java.security.MessageDigest");
        add_utf8("getInstance");
        add_utf8("SHA1");
        add_utf8("AES/ECB");
        buf_add(8'hFF);
        send_file();
    endtask

    task automatic test_tags_and_errors();
        start_file(16'd20);
        foreach (other_tags[i])
            add_other(other_tags[i]);
        send_file();
        start_file(16'd3);
        add_other(8'd5);
        add_utf8("initialize");
        send_file();
        start_file(16'd2);
        add_other(8'd6);
        repeat (4) buf_add(8'($urandom));
        send_file();
        start_file(16'd3);
        add_utf8("DES/ECB");
        buf_add(TAG_BAD);
        buf_add(8'hFF);
        send_file();
        start_file(16'd3);
        add_utf8("getInstance");
        buf_add(8'd0);
        send_file();
        start_file(16'd3);
        add_utf8("MD5withRSA");
        void'(file_buf.pop_back());
        send_file();
        start_file(16'd50);
        add_int(32'hFFFF_FFFF);
        add_utf8("SHA1withRSA");
        send_file();
    endtask

    task automatic test_backpressure();
        hold_cycles = 300;
        burst_left = 200;
        for (int i = 0; i < 40; i++)
            send_byte(8'($urandom), 1'b1);
    endtask

    task automatic test_random_files();
        int slots;
        int n;
        int kind;
        string s;
        while (bytes_sent < 850)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                file_buf = {};
                repeat ($urandom_range(1, 30)) buf_add(8'($urandom));
            end
            else
            begin
                start_file(16'd0);
                if (kind == 1)
                    file_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
                slots = 0;
                n = $urandom_range(1, 5);
                for (int e = 0; e < n; e++)
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3:
                        begin
                            s = weak_names[$urandom_range(0, 19)];
                            if ($urandom_range(0, 4) == 0)
                                s[$urandom_range(0, s.len() - 1)] = 8'($urandom);
                            add_utf8(s);
                            slots++;
                        end
                        4, 5:
                        begin
                            case ($urandom_range(0, 3))
                                0: add_int(32'd512);
                                1: add_int(32'd768);
                                2: add_int(32'd1024);
                                default: add_int($urandom);
                            endcase
                            slots++;
                        end
                        6:
                        begin
                            buf_add(8'($urandom));
                            repeat ($urandom_range(0, 8)) buf_add(8'($urandom));
                            slots++;
                        end
                        default:
                        begin
                            kind = other_tags[$urandom_range(0, 14)];
                            add_other(8'(kind));
                            slots += (kind == 5 || kind == 6) ? 2 : 1;
                        end
                    endcase
                end
                slots = ($urandom_range(0, 4) == 0) ? $urandom_range(0, slots + 2) : slots + 1;
                file_buf[8] = 8'(slots >> 8);
                file_buf[9] = 8'(slots);
                if ($urandom_range(0, 5) == 0)
                    file_buf = file_buf[0:$urandom_range(0, file_buf.size() - 1)];
                else if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 6)) buf_add(8'($urandom));
            end
            send_file();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        mismatches = 0;
        hold_cycles = 0;
        rx_mode = 0;
        burst_left = 0;
        bytes_sent = 0;
        scan_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_length_and_magic();
        test_weak_flags();
        test_tags_and_errors();
        test_backpressure();
        test_random_files();
        push <= 1'b0;
        for (int i = 0; i < 5000 && expected_results.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        result_t got;
        result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && pop && !empty)
            begin
                got = '{digest_weak, cipher_weak, signature_weak, keysize_weak, scan_status};
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.digest_weak !== want.digest_weak
                        || got.cipher_weak !== want.cipher_weak
                        || got.signature_weak !== want.signature_weak
                        || got.keysize_weak !== want.keysize_weak
                        || got.scan_status !== want.scan_status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                pop <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 40) == 0)
                    rx_mode = $urandom_range(0, 2);
                case (rx_mode)
                    0: pop <= 1'b1;
                    1: pop <= 1'($urandom);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

[class_constant_pool_crypto_scan.f]
rtl/core/ccp_scan_pkg.sv
rtl/core/ccp_scan_fifo.sv
rtl/core/ccp_scan_parse.sv
rtl/core/class_constant_pool_crypto_scan.sv
bench/testbench.sv
